// File: sv/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the timer bank checkers.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define AST_SAME(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed in %m");

// Next-cycle implication, disabled while reset is asserted.
`define AST_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed in %m");

`endif

// File: sv/ptb_pkg.sv
// ---------------------------------------------------------------------------
// ptb_pkg
// Types and codes shared by the periodic and timeout timer bank.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package ptb_pkg;

	localparam int ACTION_W = 3;
	localparam int INDEX_W  = 3;
	localparam int VALUE_W  = 16;
	localparam int CFG_W    = 4;
	localparam int CFG_IDX_W = 1;

	typedef enum logic [ACTION_W-1:0] {
		ACT_TICK          = 3'd0,
		ACT_START_PERIOD  = 3'd1,
		ACT_STOP_PERIOD   = 3'd2,
		ACT_QUERY_PERIOD  = 3'd3,
		ACT_CLEAR_PERIOD  = 3'd4,
		ACT_START_TIMEOUT = 3'd5,
		ACT_STOP_TIMEOUT  = 3'd6,
		ACT_QUERY_TIMEOUT = 3'd7
	} action_t;

	localparam logic [CFG_IDX_W-1:0] CFG_PERIODS_IN_USE  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUTS_IN_USE = 1'b1;

	localparam logic [CFG_W-1:0] CFG_RESET_IN_USE = 4'd8;

	typedef struct packed {
		action_t             action;
		logic [INDEX_W-1:0]  index;
		logic [VALUE_W-1:0]  value;
	} in_item_t;

	typedef struct packed {
		logic accepted;
		logic done_res;
	} out_item_t;

	// controller -> datapath
	typedef struct packed {
		logic apply;   // commit the state update of the incoming item
		logic load;    // capture the result into the output register
	} ptb_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic is_tick;
		logic idx_ok;
	} ptb_status_t;

endpackage

// File: sv/ptb_ctrl.sv
// ---------------------------------------------------------------------------
// ptb_ctrl
// Handshake controller: owns the output slot and gates datapath updates.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ptb_ctrl
	import ptb_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	output logic        out_valid,
	input  logic        out_ready,
	input  ptb_status_t status,
	output ptb_cmd_t    cmd
);

	typedef enum logic [1:0] {
		ST_EMPTY = 2'b01,
		ST_FULL  = 2'b10
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   in_fire;

	// take a new item whenever the output slot is free or drains this cycle
	assign in_ready = (state_q == ST_EMPTY) || out_ready;
	assign out_valid = (state_q == ST_FULL);
	assign in_fire = in_valid && in_ready;

	assign cmd.apply = in_fire && (status.is_tick || status.idx_ok);
	assign cmd.load  = in_fire;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_EMPTY: begin
				if (in_fire) state_d = ST_FULL;
			end
			ST_FULL: begin
				if (out_ready && !in_fire) state_d = ST_EMPTY;
			end
			default: state_d = ST_EMPTY;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_EMPTY;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// File: sv/ptb_dpath.sv
// ---------------------------------------------------------------------------
// ptb_dpath
// Timer state, in-use registers, per-entry tick logic and result register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ptb_dpath
	import ptb_pkg::*;
#(
	parameter int NUM_PERIODS  = 8,
	parameter int NUM_TIMEOUTS = 8,
	parameter int COUNT_BITS   = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  in_item_t             in_item,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  ptb_cmd_t             cmd,
	output ptb_status_t          status,
	output out_item_t            out_item
);

	logic [CFG_W-1:0] periods_in_use_q;
	logic [CFG_W-1:0] timeouts_in_use_q;

	logic [COUNT_BITS-1:0] p_count_q  [NUM_PERIODS];
	logic [COUNT_BITS-1:0] p_reload_q [NUM_PERIODS];
	logic [NUM_PERIODS-1:0] p_active_q;
	logic [NUM_PERIODS-1:0] p_flag_q;
	logic [COUNT_BITS-1:0] t_count_q  [NUM_TIMEOUTS];

	logic [COUNT_BITS-1:0] p_count_d  [NUM_PERIODS];
	logic [COUNT_BITS-1:0] p_reload_d [NUM_PERIODS];
	logic [NUM_PERIODS-1:0] p_active_d;
	logic [NUM_PERIODS-1:0] p_flag_d;
	logic [COUNT_BITS-1:0] t_count_d  [NUM_TIMEOUTS];

	logic [NUM_PERIODS-1:0]  p_sel;
	logic [NUM_PERIODS-1:0]  p_en;
	logic [NUM_TIMEOUTS-1:0] t_sel;
	logic [NUM_TIMEOUTS-1:0] t_en;
	logic [NUM_TIMEOUTS-1:0] t_zero;

	logic                  is_period_cmd;
	logic                  p_idx_ok;
	logic                  t_idx_ok;
	logic                  idx_ok;
	logic [COUNT_BITS-1:0] load_val;
	out_item_t             res_d;
	out_item_t             res_q;

	assign load_val = COUNT_BITS'(in_item.value);
	assign is_period_cmd = (in_item.action == ACT_START_PERIOD) ||
		(in_item.action == ACT_STOP_PERIOD) || (in_item.action == ACT_QUERY_PERIOD) ||
		(in_item.action == ACT_CLEAR_PERIOD);

	assign p_idx_ok = ({1'b0, in_item.index} < periods_in_use_q) &&
		(32'(in_item.index) < NUM_PERIODS);
	assign t_idx_ok = ({1'b0, in_item.index} < timeouts_in_use_q) &&
		(32'(in_item.index) < NUM_TIMEOUTS);
	assign idx_ok = is_period_cmd ? p_idx_ok : t_idx_ok;

	assign status.is_tick = (in_item.action == ACT_TICK);
	assign status.idx_ok  = (in_item.action != ACT_TICK) && idx_ok;

	// per-entry selects and in-use enables
	always_comb begin
		for (int i = 0; i < NUM_PERIODS; i++) begin
			p_sel[i] = (32'(in_item.index) == 32'(i));
			p_en[i]  = (32'(i) < 32'(periods_in_use_q));
		end
		for (int i = 0; i < NUM_TIMEOUTS; i++) begin
			t_sel[i]  = (32'(in_item.index) == 32'(i));
			t_en[i]   = (32'(i) < 32'(timeouts_in_use_q));
			t_zero[i] = (t_count_q[i] == '0);
		end
	end

	// result of the incoming item
	always_comb begin
		res_d.accepted = status.is_tick || idx_ok;
		res_d.done_res = 1'b0;
		if (idx_ok) begin
			if (in_item.action == ACT_QUERY_PERIOD) res_d.done_res = |(p_flag_q & p_sel);
			if (in_item.action == ACT_QUERY_TIMEOUT) res_d.done_res = |(t_zero & t_sel);
		end
	end

	// next state: tick advances every enabled active period and every enabled nonzero timeout, commands touch one entry
	always_comb begin
		logic [COUNT_BITS-1:0] dec;
		dec        = '0;
		p_active_d = p_active_q;
		p_flag_d   = p_flag_q;
		for (int i = 0; i < NUM_PERIODS; i++) begin
			p_count_d[i]  = p_count_q[i];
			p_reload_d[i] = p_reload_q[i];
		end
		for (int i = 0; i < NUM_TIMEOUTS; i++) begin
			t_count_d[i] = t_count_q[i];
		end
		if (cmd.apply) begin
			for (int i = 0; i < NUM_PERIODS; i++) begin
				dec = p_count_q[i] - COUNT_BITS'(1);
				unique case (in_item.action)
					ACT_TICK: begin
						if (p_en[i] && p_active_q[i]) begin
							if (dec == '0) begin
								p_flag_d[i]  = 1'b1;
								p_count_d[i] = p_reload_q[i];
							end else begin
								p_count_d[i] = dec;
							end
						end
					end
					ACT_START_PERIOD: begin
						if (p_sel[i]) begin
							p_active_d[i] = 1'b1;
							p_flag_d[i]   = 1'b0;
							p_reload_d[i] = load_val;
							p_count_d[i]  = load_val;
						end
					end
					ACT_STOP_PERIOD: begin
						if (p_sel[i]) p_active_d[i] = 1'b0;
					end
					ACT_CLEAR_PERIOD: begin
						if (p_sel[i]) p_flag_d[i] = 1'b0;
					end
					default: ;
				endcase
			end
			for (int i = 0; i < NUM_TIMEOUTS; i++) begin
				unique case (in_item.action)
					ACT_TICK: begin
						if (t_en[i] && !t_zero[i]) t_count_d[i] = t_count_q[i] - COUNT_BITS'(1);
					end
					ACT_START_TIMEOUT: begin
						if (t_sel[i]) t_count_d[i] = load_val;
					end
					ACT_STOP_TIMEOUT: begin
						if (t_sel[i]) t_count_d[i] = '0;
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			periods_in_use_q  <= CFG_RESET_IN_USE;
			timeouts_in_use_q <= CFG_RESET_IN_USE;
			p_active_q <= '0;
			p_flag_q   <= '0;
			for (int i = 0; i < NUM_PERIODS; i++) begin
				p_count_q[i]  <= '0;
				p_reload_q[i] <= '0;
			end
			for (int i = 0; i < NUM_TIMEOUTS; i++) begin
				t_count_q[i] <= '0;
			end
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_PERIODS_IN_USE:  periods_in_use_q  <= cfg_data;
					CFG_TIMEOUTS_IN_USE: timeouts_in_use_q <= cfg_data;
					default: ;
				endcase
			end
			p_active_q <= p_active_d;
			p_flag_q   <= p_flag_d;
			for (int i = 0; i < NUM_PERIODS; i++) begin
				p_count_q[i]  <= p_count_d[i];
				p_reload_q[i] <= p_reload_d[i];
			end
			for (int i = 0; i < NUM_TIMEOUTS; i++) begin
				t_count_q[i] <= t_count_d[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) res_q <= res_d;
	end

	assign out_item = res_q;

endmodule

// File: sv/periodic_and_timeout_timer_bank_unit.sv
// ---------------------------------------------------------------------------
// periodic_and_timeout_timer_bank_unit
// Bank of periodic timers and one-shot timeouts advanced by tick items.
// ---------------------------------------------------------------------------
//
//   channel  | signals                          | direction | payload
//   ---------+----------------------------------+-----------+---------------------
//   input    | in_valid / in_ready / in_item    | in        | action, index, value
//   output   | out_valid / out_ready / out_item | out       | accepted, done_res
//   config   | cfg_we / cfg_index / cfg_data    | in        | in-use counts
//
// The timer state updates and the result is written into the output register
// at the edge that accepts the transfer. The output register frees up in the
// same cycle it drains, so with out_ready high an item can be accepted every cycle.
// A stalled result blocks new transfers only while the output register is full.
// Reset clears all timers and flags and sets both in-use counts to eight.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module periodic_and_timeout_timer_bank_unit
	import ptb_pkg::*;
#(
	parameter int NUM_PERIODS  = 8,
	parameter int NUM_TIMEOUTS = 8,
	parameter int COUNT_BITS   = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  in_item_t             in_item,
	output logic                 out_valid,
	input  logic                 out_ready,
	output out_item_t            out_item,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	ptb_cmd_t    cmd;
	ptb_status_t status;

	// Controller: decide when a transfer happens and whether it may commit.
	ptb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	// Datapath: hold the counters, range-check the index, advance on a tick,
	// and register the result of every transfer.
	ptb_dpath #(
		.NUM_PERIODS  (NUM_PERIODS),
		.NUM_TIMEOUTS (NUM_TIMEOUTS),
		.COUNT_BITS   (COUNT_BITS)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_item   (in_item),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.status    (status),
		.out_item  (out_item)
	);

endmodule

// File: sv/ptb_checker.sv
// ---------------------------------------------------------------------------
// ptb_checker
// Port-level checks for the timer bank, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ptb_checker
	import ptb_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_ready,
	input in_item_t             in_item,
	input logic                 out_valid,
	input logic                 out_ready,
	input out_item_t            out_item,
	input logic                 cfg_we,
	input logic [CFG_IDX_W-1:0] cfg_index,
	input logic [CFG_W-1:0]     cfg_data
);

	logic in_fire;
	logic cfg_seen;

	assign in_fire = in_valid && in_ready;
	assign cfg_seen = cfg_we && (cfg_index == CFG_PERIODS_IN_USE || cfg_data != '0);

	`AST_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_item))
	`AST_NEXT(a_fire_gives_result, clk, arst_n, in_fire, out_valid)
	`AST_SAME(a_free_slot_ready, clk, arst_n, !out_valid, in_ready)
	`AST_SAME(a_reject_no_done, clk, arst_n, out_valid && !out_item.accepted, !out_item.done_res)
	`AST_NEXT(a_tick_result, clk, arst_n, in_fire && in_item.action == ACT_TICK && !cfg_seen,
		out_item.accepted && !out_item.done_res)

endmodule

bind periodic_and_timeout_timer_bank_unit ptb_checker u_ptb_checker (.*);
